[rtl/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants for the LED pattern controller.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Width of the internal time stamp and elapsed-time arithmetic.
  localparam int unsigned TimeBits = 32;

  localparam int unsigned SysTimeBits = 32;
  localparam int unsigned DelayBits   = 16;
  localparam int unsigned RatioBits   = 8;
  localparam int unsigned ModeBits    = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [ModeBits-1:0] {
    ModeOff        = 3'd0,
    ModeOn         = 3'd1,
    ModeDelayedOff = 3'd2,
    ModeFastFlash  = 3'd3,
    ModeSlowFlash  = 3'd4,
    ModeFastBlink  = 3'd5,
    ModeSlowBlink  = 3'd6,
    ModeHold       = 3'd7
  } lpc_mode_e;

  typedef enum logic {
    CmdTick    = 1'b0,
    CmdSetMode = 1'b1
  } lpc_cmd_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegActiveLow      = 3'd0,
    RegDelayedOffTime = 3'd1,
    RegFastFlashTime  = 3'd2,
    RegSlowFlashTime  = 3'd3,
    RegBlinkStepTime  = 3'd4,
    RegFastBlinkRatio = 3'd5,
    RegSlowBlinkRatio = 3'd6,
    RegUnused         = 3'd7
  } lpc_reg_e;

  typedef struct packed {
    logic                   command;
    logic [SysTimeBits-1:0] sys_time;
    logic [ModeBits-1:0]    new_mode;
  } lpc_in_t;

  typedef struct packed {
    logic                pin_level;
    logic [ModeBits-1:0] mode_now;
  } lpc_out_t;

  typedef struct packed {
    logic                 active_low;
    logic [DelayBits-1:0] delayed_off_time;
    logic [DelayBits-1:0] fast_flash_time;
    logic [DelayBits-1:0] slow_flash_time;
    logic [DelayBits-1:0] blink_step_time;
    logic [RatioBits-1:0] fast_blink_top;
    logic [RatioBits-1:0] slow_blink_top;
  } lpc_cfg_t;

endpackage

[rtl/lpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lpc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lpc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lpc_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [lpc_pkg::CfgDataBits-1:0]     cfg_data_i,
  output lpc_pkg::lpc_cfg_t                   cfg_o
);

  lpc_pkg::lpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lpc_pkg::lpc_reg_e'(cfg_idx_i))
        lpc_pkg::RegActiveLow:      cfg_d.active_low       = cfg_data_i[0];
        lpc_pkg::RegDelayedOffTime: cfg_d.delayed_off_time = cfg_data_i;
        lpc_pkg::RegFastFlashTime:  cfg_d.fast_flash_time  = cfg_data_i;
        lpc_pkg::RegSlowFlashTime:  cfg_d.slow_flash_time  = cfg_data_i;
        lpc_pkg::RegBlinkStepTime:  cfg_d.blink_step_time  = cfg_data_i;
        lpc_pkg::RegFastBlinkRatio:
          cfg_d.fast_blink_top = cfg_data_i[lpc_pkg::RatioBits-1:0];
        lpc_pkg::RegSlowBlinkRatio:
          cfg_d.slow_blink_top = cfg_data_i[lpc_pkg::RatioBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low       <= 1'b0;
      cfg_q.delayed_off_time <= 16'd1000;
      cfg_q.fast_flash_time  <= 16'd100;
      cfg_q.slow_flash_time  <= 16'd500;
      cfg_q.blink_step_time  <= 16'd100;
      cfg_q.fast_blink_top   <= 8'd2;
      cfg_q.slow_blink_top   <= 8'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/lpc_core.sv]
// ----------------------------------------------------------------------------
// lpc_core
// Pattern state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module lpc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lpc_pkg::lpc_in_t  item_i,
  input  lpc_pkg::lpc_cfg_t cfg_i,
  output lpc_pkg::lpc_out_t result_o
);

  lpc_pkg::lpc_mode_e                  mode_q, mode_d;
  logic [lpc_pkg::TimeBits-1:0]        stamp_q, stamp_d;
  logic [lpc_pkg::RatioBits-1:0]       count_q, count_d;
  logic                                pin_q, pin_d;

  logic [lpc_pkg::TimeBits-1:0]        now;
  logic [lpc_pkg::TimeBits-1:0]        elapsed;
  logic [lpc_pkg::DelayBits-1:0]       delay;
  logic [lpc_pkg::RatioBits-1:0]       ratio;
  logic                                lit;
  logic                                fire;

  assign now     = lpc_pkg::TimeBits'(item_i.sys_time);
  assign elapsed = now - stamp_q;
  assign lit     = ~cfg_i.active_low;

  // Delay and ratio for whichever timed mode is active
  always_comb begin
    delay = cfg_i.delayed_off_time;
    ratio = cfg_i.fast_blink_top;
    unique case (mode_q)
      lpc_pkg::ModeFastFlash: delay = cfg_i.fast_flash_time;
      lpc_pkg::ModeSlowFlash: delay = cfg_i.slow_flash_time;
      lpc_pkg::ModeFastBlink: delay = cfg_i.blink_step_time;
      lpc_pkg::ModeSlowBlink: begin
        delay = cfg_i.blink_step_time;
        ratio = cfg_i.slow_blink_top;
      end
      default: ;
    endcase
  end

  assign fire = elapsed > lpc_pkg::TimeBits'(delay);

  always_comb begin
    mode_d  = mode_q;
    stamp_d = stamp_q;
    count_d = count_q;
    pin_d   = pin_q;
    if (lpc_pkg::lpc_cmd_e'(item_i.command) == lpc_pkg::CmdSetMode) begin
      // pin and counter wait for the next tick
      mode_d  = lpc_pkg::lpc_mode_e'(item_i.new_mode);
      stamp_d = now;
    end else begin
      unique case (mode_q)
        lpc_pkg::ModeOff: pin_d = ~lit;
        lpc_pkg::ModeOn:  pin_d = lit;
        lpc_pkg::ModeDelayedOff: begin
          // expiry tick still lights; dark on the following tick
          pin_d = lit;
          if (fire) mode_d = lpc_pkg::ModeOff;
        end
        lpc_pkg::ModeFastFlash, lpc_pkg::ModeSlowFlash: begin
          if (fire) begin
            pin_d   = ~pin_q;
            stamp_d = now;
          end
        end
        lpc_pkg::ModeFastBlink, lpc_pkg::ModeSlowBlink: begin
          if (fire) begin
            stamp_d = now;
            count_d = (count_q > ratio) ? '0 : count_q + 1'b1;
            pin_d   = (count_d == '0) ? lit : ~lit;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lpc_pkg::ModeOff;
      stamp_q <= '0;
      count_q <= '0;
      pin_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      stamp_q <= stamp_d;
      count_q <= count_d;
      pin_q   <= pin_d;
    end
  end

  assign result_o.pin_level = pin_d;
  assign result_o.mode_now  = mode_d;

endmodule

[rtl/led_pattern_controller_top.sv]
// ----------------------------------------------------------------------------
// led_pattern_controller_top
// LED pattern controller: input register, single-pass update, result register.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------
//  in       | in_valid_i / in_stall_o     | in_data_i  (lpc_in_t)
//  out      | out_valid_o / out_stall_i   | out_data_o (lpc_out_t)
//  cfg      | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled; an item taken
//  reaches the output through the input register, then the result register.
//  The state update is one subtract and compare plus an 8-bit counter step.
//  Reset restores state, config and valid flags; s0_q and out_q are not reset.
//  A stall at the output holds the result register; the input register still
//  takes one item, and the input stalls only once that register is full.
// ----------------------------------------------------------------------------
module led_pattern_controller_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lpc_pkg::lpc_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lpc_pkg::lpc_out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [lpc_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [lpc_pkg::CfgDataBits-1:0]  cfg_data_i
);

  lpc_pkg::lpc_cfg_t cfg;
  lpc_pkg::lpc_in_t  s0_q;
  logic              s0_valid_q;
  lpc_pkg::lpc_out_t result;
  lpc_pkg::lpc_out_t out_q;
  logic              out_valid_q;
  logic              advance;
  logic              step;
  logic              in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s0_valid_q && advance;
  assign in_stall_o = s0_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  lpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s0_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // an empty input register fills even while the output is stalled
      if (advance || in_take) s0_valid_q <= in_take;
      if (advance) out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s0_q  <= in_data_i;
    if (step)    out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A staged item that moves on always lands in the result register
  a_step_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("staged item lost on its way to the output");

  // A set-mode item reports the mode it carried
  a_set_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && s0_q.command == lpc_pkg::CmdSetMode)
      |=> out_data_o.mode_now == $past(s0_q.new_mode))
    else $error("set-mode item reported a different mode");

  // A set-mode item leaves the pin where the previous item put it
  a_set_keeps_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && s0_q.command == lpc_pkg::CmdSetMode && out_valid_o)
      |=> out_data_o.pin_level == $past(out_data_o.pin_level))
    else $error("set-mode item changed the pin");
`endif

endmodule
